>>> rtl/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int VALUE_WIDTH = 32;
    localparam int PLANE_W     = 3;
    localparam int COMP_W      = 2;
    localparam int STEP_W      = 3;
    localparam int NORM_FRAC   = 30;
    localparam int OFS_FRAC    = 16;

    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);
    localparam logic [COMP_W-1:0]  LAST_COMP  = COMP_W'(3);
    localparam logic [COMP_W-1:0]  LAST_SQ    = COMP_W'(2);
    localparam logic [STEP_W-1:0]  STEP_OFS   = STEP_W'(3);
    localparam logic [STEP_W-1:0]  STEP_CHECK = STEP_W'(4);

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_TEST   = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_C,
        ST_SQ_INIT,
        ST_SQ_RUN,
        ST_SQRT_INIT,
        ST_SQRT_RUN,
        ST_LEN_CHECK,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_ZERO_STORE,
        ST_TEST,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_LOAD,
        CMD_RD_A,
        CMD_RD_C,
        CMD_SQ_INIT,
        CMD_SQ_RUN,
        CMD_SQRT_INIT,
        CMD_SQRT_RUN,
        CMD_DIV_INIT,
        CMD_DIV_RUN,
        CMD_DIV_STORE,
        CMD_ZERO_STORE,
        CMD_TEST,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [PLANE_W-1:0]  plane;
        logic [COMP_W-1:0]   comp;
        logic [STEP_W-1:0]   step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
        logic len_zero;
        logic outside;
        logic out_free;
    } ctrl_status_t;

    // plane order: right, left, down, up, far, near
    function automatic logic [1:0] plane_col(input logic [PLANE_W-1:0] p);
        logic [1:0] c;
        unique case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic plane_add(input logic [PLANE_W-1:0] p);
        logic a;
        unique case (p)
            3'd1, 3'd2, 3'd5: a = 1'b1;
            default:          a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/frustum_sphere_cull_top.sv
`timescale 1ns / 1ps

// Frustum plane extraction and sphere culling. Each request carries an op in
// tuser: write one matrix entry, commit the matrix into six normalized planes,
// or test a sphere. Only a sphere test returns a result, the inside flag. One
// request is worked on at a time; a test examines the planes in order (one
// shared multiplier, three products and the offset term per plane), stopping
// at the first plane that rejects the sphere. A commit runs a bit-serial
// squarer, a one-bit-per-cycle square root and a one-bit-per-cycle divider per
// plane. A pending result in the output register does not block the next
// request.
module frustum_sphere_cull_top #(
    parameter int VALUE_WIDTH = fsc_pkg::VALUE_WIDTH,
    parameter int DATA_W      = ((4 + 5 * VALUE_WIDTH) + 7) / 8 * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // row[1:0], col, value, center_x, center_y, center_z, radius, zero fill
    input  logic [DATA_W-1:0] s_axis_tdata,
    // op
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // inside_res, zero fill
    output logic [7:0]        m_axis_tdata
);
    import fsc_pkg::*;

    localparam int W = VALUE_WIDTH;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         inside_res;

    fsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .op      (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    fsc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .row        (s_axis_tdata[1:0]),
        .col        (s_axis_tdata[3:2]),
        .value      (s_axis_tdata[4 +: W]),
        .center_x   (s_axis_tdata[4 + W +: W]),
        .center_y   (s_axis_tdata[4 + 2 * W +: W]),
        .center_z   (s_axis_tdata[4 + 3 * W +: W]),
        .radius     (s_axis_tdata[4 + 4 * W +: W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .inside_res (inside_res)
    );

    assign m_axis_tdata = {7'b0, inside_res};

endmodule

>>> rtl/fsc_ctrl.sv
`timescale 1ns / 1ps

module fsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    input  logic [1:0]           op,
    output logic                 s_ready,
    input  fsc_pkg::ctrl_status_t status,
    output fsc_pkg::ctrl_cmd_t   cmd
);
    import fsc_pkg::*;

    state_t              state_reg, state_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;
    logic [COMP_W-1:0]   comp_reg,  comp_next;
    logic [STEP_W-1:0]   step_reg,  step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            comp_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (s_valid && op == OP_COMMIT)
                begin
                    state_next = ST_RD_A;
                    plane_next = '0;
                    comp_next  = '0;
                end
                else if (s_valid && op == OP_TEST)
                begin
                    state_next = ST_TEST;
                    plane_next = '0;
                    step_next  = '0;
                end
            end
            ST_RD_A:
                state_next = ST_RD_C;
            ST_RD_C:
            begin
                if (comp_reg == LAST_COMP)
                begin
                    state_next = ST_SQ_INIT;
                    comp_next  = '0;
                end
                else
                begin
                    state_next = ST_RD_A;
                    comp_next  = comp_reg + 1'b1;
                end
            end
            ST_SQ_INIT:
                state_next = ST_SQ_RUN;
            ST_SQ_RUN:
            begin
                if (status.done)
                begin
                    if (comp_reg == LAST_SQ)
                        state_next = ST_SQRT_INIT;
                    else
                    begin
                        state_next = ST_SQ_INIT;
                        comp_next  = comp_reg + 1'b1;
                    end
                end
            end
            ST_SQRT_INIT:
                state_next = ST_SQRT_RUN;
            ST_SQRT_RUN:
            begin
                if (status.done)
                    state_next = ST_LEN_CHECK;
            end
            ST_LEN_CHECK:
            begin
                comp_next  = '0;
                state_next = status.len_zero ? ST_ZERO_STORE : ST_DIV_INIT;
            end
            ST_DIV_INIT:
                state_next = ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (status.done)
                    state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE, ST_ZERO_STORE:
            begin
                if (state_reg == ST_DIV_STORE && comp_reg != LAST_COMP)
                begin
                    state_next = ST_DIV_INIT;
                    comp_next  = comp_reg + 1'b1;
                end
                else if (plane_reg == LAST_PLANE)
                    state_next = ST_IDLE;
                else
                begin
                    state_next = ST_RD_A;
                    plane_next = plane_reg + 1'b1;
                    comp_next  = '0;
                end
            end
            ST_TEST:
            begin
                if (step_reg == STEP_CHECK)
                begin
                    if (status.outside || plane_reg == LAST_PLANE)
                        state_next = ST_RESULT;
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                        step_next  = '0;
                    end
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_ready   = 1'b0;
        cmd.op    = CMD_NONE;
        cmd.plane = plane_reg;
        cmd.comp  = comp_reg;
        cmd.step  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid && op == OP_WRITE)
                    cmd.op = CMD_WRITE;
                else if (s_valid && op == OP_TEST)
                    cmd.op = CMD_LOAD;
            end
            ST_RD_A:       cmd.op = CMD_RD_A;
            ST_RD_C:       cmd.op = CMD_RD_C;
            ST_SQ_INIT:    cmd.op = CMD_SQ_INIT;
            ST_SQ_RUN:     cmd.op = CMD_SQ_RUN;
            ST_SQRT_INIT:  cmd.op = CMD_SQRT_INIT;
            ST_SQRT_RUN:   cmd.op = CMD_SQRT_RUN;
            ST_LEN_CHECK:  cmd.op = CMD_NONE;
            ST_DIV_INIT:   cmd.op = CMD_DIV_INIT;
            ST_DIV_RUN:    cmd.op = CMD_DIV_RUN;
            ST_DIV_STORE:  cmd.op = CMD_DIV_STORE;
            ST_ZERO_STORE: cmd.op = CMD_ZERO_STORE;
            ST_TEST:       cmd.op = CMD_TEST;
            ST_RESULT:     cmd.op = status.out_free ? CMD_EMIT : CMD_NONE;
            default:       cmd.op = CMD_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg <= LAST_PLANE)
        else $error("plane index out of range");

    a_store_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STORE |-> !status.len_zero)
        else $error("divide store with zero length");

    a_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && step_reg == STEP_CHECK && status.outside)
        |=> state_reg == ST_RESULT)
        else $error("outside plane did not end the test");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TEST |-> step_reg <= STEP_CHECK)
        else $error("test step out of range");
`endif

endmodule

>>> rtl/fsc_datapath.sv
`timescale 1ns / 1ps

module fsc_datapath #(
    parameter int VALUE_WIDTH = fsc_pkg::VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsc_pkg::ctrl_cmd_t            cmd,
    output fsc_pkg::ctrl_status_t         status,
    input  logic [1:0]                    row,
    input  logic [1:0]                    col,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic signed [VALUE_WIDTH-1:0] center_x,
    input  logic signed [VALUE_WIDTH-1:0] center_y,
    input  logic signed [VALUE_WIDTH-1:0] center_z,
    input  logic signed [VALUE_WIDTH-1:0] radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res
);
    import fsc_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int RAW_W = W + 1;
    localparam int SW    = 2 * W + 2;
    localparam int RW    = W + 1;
    localparam int NW    = W + NORM_FRAC + 1;
    localparam int PW    = W + 32;
    localparam int AW    = W + 35;
    localparam int CW    = $clog2(NW + 1);

    logic signed [W-1:0]     matrix_reg [16];
    logic signed [31:0]      normal_reg [NUM_PLANES][3];
    logic signed [W-1:0]     offset_reg [NUM_PLANES];

    logic signed [W-1:0]     a_reg;
    logic signed [RAW_W-1:0] raw_reg [4];
    logic [SW-1:0]           sum_reg;
    logic [SW-1:0]           mcand_reg;
    logic [RAW_W-1:0]        mplier_reg;
    logic [SW-1:0]           radicand_reg;
    logic [RW-1:0]           root_reg;
    logic [RW+1:0]           srem_reg;
    logic [NW-1:0]           quot_reg;
    logic [RW-1:0]           drem_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [W-1:0]     cx_reg, cy_reg, cz_reg, rad_reg;
    logic signed [AW-1:0]    term_reg;
    logic signed [AW-1:0]    acc_reg;
    logic                    inside_reg;
    logic                    out_valid_reg;
    logic                    out_data_reg;

    logic [3:0]              rd_addr;
    logic signed [W-1:0]     rd_val;
    logic signed [RAW_W-1:0] raw_sel;
    logic [RAW_W-1:0]        raw_mag;
    logic signed [RAW_W-1:0] a_ext, c_ext;
    logic [RW+3:0]           s_sh;
    logic [RW+3:0]           s_trial;
    logic [RW:0]             d_sh;
    logic                    d_bit;
    logic                    rnd;
    logic [NW:0]             q_r;
    logic [NW:0]             lim;
    logic [NW:0]             sat;
    logic                    neg;
    logic [NW-1:0]           num;
    logic signed [W-1:0]     center_sel;
    logic signed [31:0]      normal_sel;
    logic signed [PW-1:0]    prod;
    logic signed [W:0]       ofs_sum;
    logic signed [AW-1:0]    term_next;
    logic signed [AW-1:0]    acc_sum;
    logic                    outside;

    assign rd_addr = {cmd.comp, (cmd.op == CMD_RD_A) ? 2'd3 : plane_col(cmd.plane)};
    assign rd_val  = matrix_reg[rd_addr];
    assign a_ext   = {a_reg[W-1], a_reg};
    assign c_ext   = {rd_val[W-1], rd_val};
    assign raw_sel = raw_reg[cmd.comp];
    assign neg     = raw_sel[RAW_W-1];
    assign raw_mag = neg ? RAW_W'(-raw_sel) : RAW_W'(raw_sel);

    assign num = (cmd.comp == LAST_COMP) ? (NW'(raw_mag) << OFS_FRAC)
                                         : (NW'(raw_mag) << NORM_FRAC);

    assign s_sh    = {srem_reg, radicand_reg[SW-1:SW-2]};
    assign s_trial = (RW+4)'({root_reg, 2'b01});

    assign d_sh  = {drem_reg, quot_reg[NW-1]};
    assign d_bit = d_sh >= {1'b0, root_reg};

    assign rnd = {drem_reg, 1'b0} >= {1'b0, root_reg};
    assign q_r = {1'b0, quot_reg} + (NW+1)'(rnd);
    assign lim = neg ? ((NW+1)'(1) << (W - 1)) : (((NW+1)'(1) << (W - 1)) - 1'b1);
    assign sat = (q_r > lim) ? lim : q_r;

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:
            begin
                center_sel = cx_reg;
                normal_sel = normal_reg[cmd.plane][0];
            end
            2'd1:
            begin
                center_sel = cy_reg;
                normal_sel = normal_reg[cmd.plane][1];
            end
            default:
            begin
                center_sel = cz_reg;
                normal_sel = normal_reg[cmd.plane][2];
            end
        endcase
    end

    assign prod    = center_sel * normal_sel;
    assign ofs_sum = {offset_reg[cmd.plane][W-1], offset_reg[cmd.plane]}
                   + {rad_reg[W-1], rad_reg};
    assign term_next = (cmd.step == STEP_OFS)
                     ? ({{(AW-W-1){ofs_sum[W]}}, ofs_sum} <<< NORM_FRAC)
                     : {{(AW-PW){prod[PW-1]}}, prod};
    assign acc_sum = acc_reg + term_reg;
    assign outside = acc_sum[AW-1] || (acc_sum == '0);

    assign status.done     = (cmd.op == CMD_DIV_RUN) ? (cnt_reg == CW'(NW - 1))
                                                     : (cnt_reg == CW'(W));
    assign status.len_zero = (root_reg == '0);
    assign status.outside  = outside;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign inside_res = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                matrix_reg[i] <= '0;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int c = 0; c < 3; c++)
                    normal_reg[p][c] <= '0;
                offset_reg[p] <= '0;
            end
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            case (cmd.op)
                CMD_WRITE:
                    matrix_reg[{row, col}] <= value;
                CMD_DIV_STORE:
                begin
                    if (cmd.comp == LAST_COMP)
                        offset_reg[cmd.plane] <= neg ? -W'(sat) : W'(sat);
                    else
                        normal_reg[cmd.plane][cmd.comp] <= neg ? -q_r[31:0] : q_r[31:0];
                end
                CMD_ZERO_STORE:
                begin
                    for (int c = 0; c < 3; c++)
                        normal_reg[cmd.plane][c] <= '0;
                    offset_reg[cmd.plane] <= '0;
                end
                default: ;
            endcase

            case (cmd.op) inside
                CMD_SQ_INIT, CMD_SQRT_INIT, CMD_DIV_INIT:
                    cnt_reg <= '0;
                CMD_SQ_RUN, CMD_SQRT_RUN, CMD_DIV_RUN:
                    cnt_reg <= cnt_reg + 1'b1;
                default: ;
            endcase

            if (cmd.op == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                cx_reg  <= center_x;
                cy_reg  <= center_y;
                cz_reg  <= center_z;
                rad_reg <= radius;
            end
            CMD_RD_A:
                a_reg <= rd_val;
            CMD_RD_C:
                raw_reg[cmd.comp] <= plane_add(cmd.plane) ? a_ext + c_ext : a_ext - c_ext;
            CMD_SQ_INIT:
            begin
                mcand_reg  <= SW'(raw_mag);
                mplier_reg <= raw_mag;
                if (cmd.comp == '0)
                    sum_reg <= '0;
            end
            CMD_SQ_RUN:
            begin
                if (mplier_reg[0])
                    sum_reg <= sum_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            CMD_SQRT_INIT:
            begin
                radicand_reg <= sum_reg;
                root_reg     <= '0;
                srem_reg     <= '0;
            end
            CMD_SQRT_RUN:
            begin
                if (s_sh >= s_trial)
                begin
                    srem_reg <= (RW+2)'(s_sh - s_trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= (RW+2)'(s_sh);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                radicand_reg <= radicand_reg << 2;
            end
            CMD_DIV_INIT:
            begin
                quot_reg <= num;
                drem_reg <= '0;
            end
            CMD_DIV_RUN:
            begin
                drem_reg <= d_bit ? RW'(d_sh - {1'b0, root_reg}) : RW'(d_sh);
                quot_reg <= {quot_reg[NW-2:0], d_bit};
            end
            CMD_TEST:
            begin
                if (cmd.step < STEP_CHECK)
                    term_reg <= term_next;
                if (cmd.step == STEP_W'(1))
                    acc_reg <= term_reg;
                else if (cmd.step != '0)
                    acc_reg <= acc_sum;
                if (cmd.step == STEP_CHECK)
                    inside_reg <= !outside;
            end
            CMD_EMIT:
                out_data_reg <= inside_reg;
            default: ;
        endcase
    end

endmodule
